### src/assert_macros.svh
// Assertion macros used by the checker file idsa_checker.sv.
// Depends on nothing; included by the files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define IDSA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked property that also holds during reset.
`define IDSA_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/idsa_pkg.sv
// Types, codes and opcode decode for the issue decode and station allocation unit.
// No dependencies; imported by the top level.
`default_nettype none

package idsa_pkg;

	typedef enum logic [2:0] {
		UNIT_IALU   = 3'd0,
		UNIT_IMUL   = 3'd1,
		UNIT_FALU   = 3'd2,
		UNIT_FMUL   = 3'd3,
		UNIT_LOAD   = 3'd4,
		UNIT_STORE  = 3'd5,
		UNIT_BRANCH = 3'd6,
		UNIT_NONE   = 3'd7
	} unit_t;

	localparam logic [2:0] ALLOC_NONE    = 3'd0;
	localparam logic [2:0] ALLOC_COMPARE = 3'd7;

	localparam logic [3:0] ST_SB0     = 4'd0;
	localparam logic [3:0] ST_SB1     = 4'd1;
	localparam logic [3:0] ST_LB0     = 4'd2;
	localparam logic [3:0] ST_LB1     = 4'd3;
	localparam logic [3:0] ST_LB2     = 4'd4;
	localparam logic [3:0] ST_IALU0   = 4'd5;
	localparam logic [3:0] ST_IALU1   = 4'd6;
	localparam logic [3:0] ST_FALU0   = 4'd7;
	localparam logic [3:0] ST_IMUL0   = 4'd8;
	localparam logic [3:0] ST_FMUL0   = 4'd9;
	localparam logic [3:0] ST_BRANCH0 = 4'd10;
	localparam logic [3:0] ST_NONE    = 4'hF;

	localparam int unsigned NUM_STATIONS = 11;

	localparam logic [7:0] OP_BRANCH_ALWAYS = 8'h45;
	localparam logic [7:0] OP_SWI           = 8'h4C;
	localparam logic [7:0] OP_NOP           = 8'h4D;

	typedef struct packed {
		unit_t unit;
		logic  imm;
		logic  cmp;
		logic  mflags;
		logic  nflags;
	} decode_t;

	typedef struct packed {
		logic       stall_fetch;
		logic       rob_allocate;
		logic [3:0] source_station;
		logic       tag_write;
		logic       flags_tag_write;
		logic       modifies_flags;
		logic       needs_flags;
		logic       uses_immediate;
		logic       compare_only;
		logic       is_fp_alu;
		logic       is_fp_mul;
		logic [2:0] alloc_type;
	} result_t;

	// SWI, NOP and unknown opcodes fall through as UNIT_NONE.
	function automatic decode_t decode_op(input logic [7:0] op);
		decode_t d;
		d.unit   = UNIT_NONE;
		d.imm    = 1'b0;
		d.cmp    = 1'b0;
		d.mflags = 1'b0;
		d.nflags = 1'b0;
		priority if (op <= 8'h0D) begin
			d.unit   = (op == 8'h04 || op == 8'h05) ? UNIT_IMUL : UNIT_IALU;
			d.mflags = 1'b1;
		end else if (op >= 8'h0E && op <= 8'h1D) begin
			d.unit   = (op == 8'h12 || op == 8'h13) ? UNIT_IMUL : UNIT_IALU;
			d.imm    = 1'b1;
			d.mflags = 1'b1;
		end else if (op == 8'h1E || op == 8'h1F || op == 8'h22 ||
				(op >= 8'h29 && op <= 8'h30)) begin
			d.unit = UNIT_FALU;
		end else if (op == 8'h20 || op == 8'h21 || op == 8'h28) begin
			d.unit = UNIT_FMUL;
		end else if (op == 8'h23 || op == 8'h24 || op == 8'h27 ||
				(op >= 8'h53 && op <= 8'h5A)) begin
			d.unit = UNIT_FALU;
			d.imm  = 1'b1;
		end else if (op == 8'h25 || op == 8'h26 || op == 8'h52) begin
			d.unit = UNIT_FMUL;
			d.imm  = 1'b1;
		end else if (op == 8'h31 || op == 8'h32) begin
			d.unit = UNIT_IALU;
		end else if (op >= 8'h33 && op <= 8'h36) begin
			d.unit = UNIT_IALU;
			d.imm  = 1'b1;
		end else if (op >= 8'h37 && op <= 8'h3E) begin
			d.unit   = UNIT_IALU;
			d.cmp    = 1'b1;
			d.mflags = 1'b1;
			d.imm    = (op >= 8'h3B);
		end else if (op >= 8'h3F && op <= 8'h44) begin
			d.unit   = UNIT_FALU;
			d.cmp    = 1'b1;
			d.mflags = 1'b1;
			d.imm    = (op >= 8'h42);
		end else if (op == OP_BRANCH_ALWAYS) begin
			d.unit = UNIT_BRANCH;
		end else if (op >= 8'h46 && op <= 8'h4B) begin
			d.unit   = UNIT_BRANCH;
			d.nflags = 1'b1;
		end else if (op == 8'h4E || op == 8'h50) begin
			d.unit = UNIT_LOAD;
		end else if (op == 8'h4F || op == 8'h51) begin
			d.unit = UNIT_STORE;
		end else begin
			d.unit = UNIT_NONE;
		end
		if (op == 8'h02 || op == 8'h03 || op == 8'h10 || op == 8'h11) begin
			d.nflags = 1'b1;
		end
		return d;
	endfunction

endpackage

`default_nettype wire

### src/issue_decode_and_station_alloc_unit.sv
// Issue decode and reservation station allocation, one word per cycle.
// Depends on idsa_pkg.
//
// channel   | handshake            | word
// ----------+----------------------+------------------------------------------
// issue in  | start, busy (always 0)| inst_ready, opcode, rob_full, station_busy
// result    | done (one cycle)     | stall_fetch ... alloc_type
//
// Stages: input register, decode and priority grant, result register.
// A new word is taken every cycle; busy is never raised.
// Reset clears the valid flags only; no result follows a reset.
// The receiver cannot stall: each result shows for exactly one cycle.
`default_nettype none

module issue_decode_and_station_alloc_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        inst_ready,
	input  wire logic [7:0]  opcode,
	input  wire logic        rob_full,
	input  wire logic [10:0] station_busy,
	output logic             done,
	output logic             stall_fetch,
	output logic             rob_allocate,
	output logic [3:0]       source_station,
	output logic             tag_write,
	output logic             flags_tag_write,
	output logic             modifies_flags,
	output logic             needs_flags,
	output logic             uses_immediate,
	output logic             compare_only,
	output logic             is_fp_alu,
	output logic             is_fp_mul,
	output logic [2:0]       alloc_type
);
	import idsa_pkg::*;

	logic                    valid_s1;
	logic                    inst_ready_s1;
	logic [7:0]              opcode_s1;
	logic                    rob_full_s1;
	logic [NUM_STATIONS-1:0] busy_s1;

	decode_t                 dec;
	logic [NUM_STATIONS-1:0] free;
	logic                    found;
	logic [3:0]              grant;
	result_t                 res;

	logic                    done_s2;
	result_t                 res_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start & ~busy) begin
			inst_ready_s1 <= inst_ready;
			opcode_s1     <= opcode;
			rob_full_s1   <= rob_full;
			busy_s1       <= station_busy;
		end
	end

	assign dec  = decode_op(opcode_s1);
	assign free = ~busy_s1;

	always_comb begin
		found = 1'b0;
		grant = ST_SB0;
		unique case (dec.unit)
			UNIT_IALU: begin
				if (free[ST_IALU0]) begin
					found = 1'b1;
					grant = ST_IALU0;
				end else if (free[ST_IALU1]) begin
					found = 1'b1;
					grant = ST_IALU1;
				end
			end
			UNIT_IMUL: begin
				found = free[ST_IMUL0];
				grant = ST_IMUL0;
			end
			UNIT_FALU: begin
				found = free[ST_FALU0];
				grant = ST_FALU0;
			end
			UNIT_FMUL: begin
				found = free[ST_FMUL0];
				grant = ST_FMUL0;
			end
			UNIT_LOAD: begin
				if (free[ST_LB0]) begin
					found = 1'b1;
					grant = ST_LB0;
				end else if (free[ST_LB1]) begin
					found = 1'b1;
					grant = ST_LB1;
				end else if (free[ST_LB2]) begin
					found = 1'b1;
					grant = ST_LB2;
				end
			end
			UNIT_STORE: begin
				if (free[ST_SB0]) begin
					found = 1'b1;
					grant = ST_SB0;
				end else if (free[ST_SB1]) begin
					found = 1'b1;
					grant = ST_SB1;
				end
			end
			UNIT_BRANCH: begin
				found = free[ST_BRANCH0];
				grant = ST_BRANCH0;
			end
			UNIT_NONE: begin
				found = 1'b0;
				grant = ST_NONE;
			end
			default: begin
				found = 1'b0;
				grant = ST_SB0;
			end
		endcase
	end

	always_comb begin
		res = '0;
		if (!inst_ready_s1) begin
			res.stall_fetch = 1'b1;
		end else begin
			res.modifies_flags = dec.mflags;
			res.needs_flags    = dec.nflags;
			res.uses_immediate = dec.imm;
			res.compare_only   = dec.cmp;
			res.is_fp_alu      = (dec.unit == UNIT_FALU);
			res.is_fp_mul      = (dec.unit == UNIT_FMUL);
			res.alloc_type     = dec.cmp ? ALLOC_COMPARE :
				((dec.unit == UNIT_NONE) ? ALLOC_NONE : dec.unit);
			priority if (rob_full_s1) begin
				res.stall_fetch = 1'b1;
			end else if (dec.unit == UNIT_NONE) begin
				res.rob_allocate   = 1'b1;
				res.source_station = ST_NONE;
			end else if (!found) begin
				res.stall_fetch = 1'b1;
			end else begin
				res.rob_allocate    = 1'b1;
				res.source_station  = grant;
				res.tag_write       = ~dec.cmp && dec.unit != UNIT_STORE &&
					dec.unit != UNIT_BRANCH;
				res.flags_tag_write = dec.mflags;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_s2 <= res;
		end
	end

	assign done            = done_s2;
	assign stall_fetch     = res_s2.stall_fetch;
	assign rob_allocate    = res_s2.rob_allocate;
	assign source_station  = res_s2.source_station;
	assign tag_write       = res_s2.tag_write;
	assign flags_tag_write = res_s2.flags_tag_write;
	assign modifies_flags  = res_s2.modifies_flags;
	assign needs_flags     = res_s2.needs_flags;
	assign uses_immediate  = res_s2.uses_immediate;
	assign compare_only    = res_s2.compare_only;
	assign is_fp_alu       = res_s2.is_fp_alu;
	assign is_fp_mul       = res_s2.is_fp_mul;
	assign alloc_type      = res_s2.alloc_type;

endmodule

`default_nettype wire

### src/idsa_checker.sv
// Port-level checks for issue_decode_and_station_alloc_unit, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module idsa_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        inst_ready,
	input wire logic        done,
	input wire logic        stall_fetch,
	input wire logic        rob_allocate,
	input wire logic [3:0]  source_station,
	input wire logic        tag_write,
	input wire logic        flags_tag_write,
	input wire logic [2:0]  alloc_type
);

	`IDSA_ASSERT(a_word_in_two, clk, arst_n, (start && !busy) |-> ##2 done, "accepted word gave no result")
	`IDSA_ASSERT(a_no_extra, clk, arst_n, done |-> $past(start && !busy, 2), "result without accepted word")
	`IDSA_ASSERT(a_stall_no_grant, clk, arst_n, (done && stall_fetch) |-> (!rob_allocate && source_station == 4'd0 && !tag_write && !flags_tag_write), "grant during stall")
	`IDSA_ASSERT(a_not_ready, clk, arst_n, (start && !busy && !inst_ready) |-> ##2 (stall_fetch && alloc_type == 3'd0 && !rob_allocate), "idle slot did not stall")
	`IDSA_ASSERT(a_issue_rob, clk, arst_n, (done && !stall_fetch) |-> rob_allocate, "issue without ROB entry")

endmodule

bind issue_decode_and_station_alloc_unit idsa_checker u_idsa_checker (.*);

`default_nettype wire
